// ===== hw/rtl/apr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package apr_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 16;
    localparam int AGE_BITS   = 8;

    localparam int FRAME_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CFG_BITS   = 5;
    localparam int COUNT_BITS = 32;
    localparam int CNT_BITS   = $clog2(MAX_FRAMES + 1);
    localparam int CLAMP_BITS = ((CFG_BITS > CNT_BITS) ? CFG_BITS : CNT_BITS) + 1;

    localparam int GROUP_SIZE = 4;
    localparam int NUM_GROUPS = (MAX_FRAMES + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [CFG_BITS-1:0] FRAMES_RESET = CFG_BITS'(16);

    typedef logic [PAGE_BITS-1:0]  page_t;
    typedef logic [AGE_BITS-1:0]   age_t;
    typedef logic [FRAME_BITS-1:0] frame_idx_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CFG_BITS-1:0]   cfg_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
    } apr_cmd_t;

    typedef struct packed {
        logic out_hold;
    } apr_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/apr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire apr_pkg::apr_status_t status,
    output apr_pkg::apr_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_UPDT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd.update  = (state_reg == ST_UPDT) && !status.out_hold;
        cmd.lookup  = (state_reg == ST_LOOK);
        in_stall    = !((state_reg == ST_IDLE) || cmd.update);
        cmd.capture = in_valid && !in_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_UPDT;
            end
            ST_UPDT:
            begin
                if (cmd.update)
                begin
                    state_next = cmd.capture ? ST_LOOK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_capture_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_LOOK))
        else $error("accepted transaction did not start a lookup");

    a_look_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |=> (state_reg == ST_UPDT))
        else $error("lookup not followed by update");

endmodule

`default_nettype wire

// ===== hw/rtl/apr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apr_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire apr_pkg::apr_cmd_t    cmd,
    output apr_pkg::apr_status_t      status,
    input  wire logic                 cfg_wr_en,
    input  wire apr_pkg::cfg_t        cfg_wr_data,
    input  wire apr_pkg::page_t       page_number,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      hit,
    output apr_pkg::frame_idx_t       frame_index,
    output logic                      evicted_valid,
    output apr_pkg::page_t            evicted_page,
    output apr_pkg::count_t           hit_total,
    output apr_pkg::count_t           fault_total
);

    localparam int NF = apr_pkg::MAX_FRAMES;
    localparam int NG = apr_pkg::NUM_GROUPS;
    localparam int GS = apr_pkg::GROUP_SIZE;
    localparam int CB = apr_pkg::CLAMP_BITS;

    apr_pkg::cfg_t       frames_cfg_reg;
    logic [CB-1:0]       active_n;
    logic [NF-1:0]       active;

    apr_pkg::page_t      frame_page_reg [NF];
    logic [NF-1:0]       frame_valid_reg;
    apr_pkg::age_t       frame_age_reg [NF];
    logic [NF-1:0]       frame_ref_reg;
    apr_pkg::count_t     hit_count_reg;
    apr_pkg::count_t     fault_count_reg;

    apr_pkg::page_t      page_in_reg;

    logic                match_found;
    apr_pkg::frame_idx_t match_idx;
    logic                empty_found;
    apr_pkg::frame_idx_t empty_idx;
    logic [NG-1:0]       grp_found;
    apr_pkg::age_t       grp_age [NG];
    apr_pkg::frame_idx_t grp_idx [NG];

    logic                hit_found_reg;
    apr_pkg::frame_idx_t hit_idx_reg;
    logic                empty_found_reg;
    apr_pkg::frame_idx_t empty_idx_reg;
    logic [NG-1:0]       grp_found_reg;
    apr_pkg::age_t       grp_age_reg [NG];
    apr_pkg::frame_idx_t grp_idx_reg [NG];

    logic                best_found;
    apr_pkg::age_t       best_age;
    apr_pkg::frame_idx_t best_idx;
    apr_pkg::frame_idx_t slot;
    logic                ev_valid;

    logic                out_valid_reg;
    logic                out_hit_reg;
    apr_pkg::frame_idx_t out_idx_reg;
    logic                out_ev_reg;
    apr_pkg::page_t      out_evp_reg;

    // clamp frame count into 1..MAX_FRAMES
    always_comb
    begin
        active_n = CB'(frames_cfg_reg);
        if (active_n == '0)
        begin
            active_n = CB'(1);
        end
        else if (active_n > CB'(NF))
        begin
            active_n = CB'(NF);
        end
        for (int i = 0; i < NF; i++)
        begin
            active[i] = CB'(i) < active_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_cfg_reg <= apr_pkg::FRAMES_RESET;
        end
        else if (cfg_wr_en)
        begin
            frames_cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_in_reg <= page_number;
        end
    end

    // lookup: tag match, first empty frame, per-group minimum age
    always_comb
    begin
        int k;
        match_found = 1'b0;
        match_idx   = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int i = 0; i < NF; i++)
        begin
            if (!match_found && active[i] && frame_valid_reg[i]
                && (frame_page_reg[i] == page_in_reg))
            begin
                match_found = 1'b1;
                match_idx   = apr_pkg::FRAME_BITS'(i);
            end
            if (!empty_found && active[i] && !frame_valid_reg[i])
            begin
                empty_found = 1'b1;
                empty_idx   = apr_pkg::FRAME_BITS'(i);
            end
        end
        for (int g = 0; g < NG; g++)
        begin
            grp_found[g] = 1'b0;
            grp_age[g]   = '0;
            grp_idx[g]   = '0;
            for (int j = 0; j < GS; j++)
            begin
                k = g * GS + j;
                if (k < NF)
                begin
                    if (active[k] && (!grp_found[g] || (frame_age_reg[k] < grp_age[g])))
                    begin
                        grp_found[g] = 1'b1;
                        grp_age[g]   = frame_age_reg[k];
                        grp_idx[g]   = apr_pkg::FRAME_BITS'(k);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_found_reg   <= match_found;
            hit_idx_reg     <= match_idx;
            empty_found_reg <= empty_found;
            empty_idx_reg   <= empty_idx;
            grp_found_reg   <= grp_found;
            grp_age_reg     <= grp_age;
            grp_idx_reg     <= grp_idx;
        end
    end

    // slot selection: hit frame, else first empty frame, else lowest-age victim across groups
    always_comb
    begin
        best_found = 1'b0;
        best_age   = '0;
        best_idx   = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (grp_found_reg[g] && (!best_found || (grp_age_reg[g] < best_age)))
            begin
                best_found = 1'b1;
                best_age   = grp_age_reg[g];
                best_idx   = grp_idx_reg[g];
            end
        end
        if (hit_found_reg)
        begin
            slot = hit_idx_reg;
        end
        else if (empty_found_reg)
        begin
            slot = empty_idx_reg;
        end
        else
        begin
            slot = best_idx;
        end
        ev_valid = !hit_found_reg && !empty_found_reg;
    end

    // frame state update and aging
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= '0;
            frame_ref_reg   <= '0;
            for (int i = 0; i < NF; i++)
            begin
                frame_age_reg[i] <= '0;
            end
        end
        else if (cmd.update)
        begin
            for (int i = 0; i < NF; i++)
            begin
                logic          sel;
                logic          fill;
                logic          v;
                logic          r;
                apr_pkg::age_t a;
                sel  = (apr_pkg::FRAME_BITS'(i) == slot);
                fill = sel && !hit_found_reg;
                v    = frame_valid_reg[i] || fill;
                r    = frame_ref_reg[i] || sel;
                a    = fill ? '0 : frame_age_reg[i];
                if (active[i] && v)
                begin
                    frame_valid_reg[i] <= 1'b1;
                    frame_ref_reg[i]   <= 1'b0;
                    frame_age_reg[i]   <= {r, a[apr_pkg::AGE_BITS-1:1]};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && !hit_found_reg)
        begin
            frame_page_reg[slot] <= page_in_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_count_reg   <= '0;
            fault_count_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (hit_found_reg)
            begin
                if (hit_count_reg != '1)
                begin
                    hit_count_reg <= hit_count_reg + 1'b1;
                end
            end
            else if (fault_count_reg != '1)
            begin
                fault_count_reg <= fault_count_reg + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_hit_reg <= hit_found_reg;
            out_idx_reg <= slot;
            out_ev_reg  <= ev_valid;
            out_evp_reg <= ev_valid ? frame_page_reg[slot] : '0;
        end
    end

    assign status.out_hold = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign hit             = out_hit_reg;
    assign frame_index     = out_idx_reg;
    assign evicted_valid   = out_ev_reg;
    assign evicted_page    = out_evp_reg;
    assign hit_total       = hit_count_reg;
    assign fault_total     = fault_count_reg;

    a_update_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> out_valid_reg)
        else $error("update did not present a result");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_ev_reg))
        else $error("hit reported together with an eviction");

    a_no_evict_zero_page: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ev_reg) |-> (out_evp_reg == '0))
        else $error("evicted page nonzero without eviction");

endmodule

`default_nettype wire

// ===== hw/rtl/aging_page_replacement.sv =====
// aging page replacement, one page reference per transaction
//
// input channel: in_valid / in_stall with page_number. output channel:
// out_valid / out_stall with hit, frame_index, evicted_valid, evicted_page
// and the saturating hit_total / fault_total after that reference.
// cfg_wr_en / cfg_wr_data write frames_in_use (0 acts as 1, values above
// the built frame count act as that count); write it only while idle.
//
// a reference passes the capture register, the lookup registers and the
// output register. each reference has a lookup step (tag match, first empty
// frame, group minimum ages) followed by an update step (victim choice, fill
// and aging of all frames), and the update waits while the output is held.
// the next reference is taken in the same cycle as the update of the
// current one, so the lookup always sees the updated frame state.
//
// reset clears all valid bits, ages, reference bits and totals at once and
// sets frames_in_use to 16. while the output is stalled the finished result
// holds, one further reference can be accepted and looked up, and its
// update waits until the held result is taken.
`timescale 1ns / 1ps
`default_nettype none

module aging_page_replacement (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire apr_pkg::cfg_t   cfg_wr_data,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire apr_pkg::page_t  page_number,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic                 hit,
    output apr_pkg::frame_idx_t  frame_index,
    output logic                 evicted_valid,
    output apr_pkg::page_t       evicted_page,
    output apr_pkg::count_t      hit_total,
    output apr_pkg::count_t      fault_total
);

    apr_pkg::apr_cmd_t    cmd;
    apr_pkg::apr_status_t status;

    apr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    apr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .hit_total     (hit_total),
        .fault_total   (fault_total)
    );

endmodule

`default_nettype wire
